// ----- design/pfba_pkg.sv -----
package pfba_pkg;

    // Sizing of the page map.
    localparam int NUM_PAGES      = 512;
    localparam int PAGE_SIZE_LOG2 = 12;
    localparam int MAP_BITS       = 32;
    localparam int MAP_WORDS      = (NUM_PAGES + MAP_BITS - 1) / MAP_BITS;
    localparam int BIT_W          = $clog2(MAP_BITS);
    localparam int WORD_W         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PAGE_W         = WORD_W + BIT_W;
    localparam int TAIL_PAGES     = NUM_PAGES % MAP_BITS;

    // Field widths of the command and result words.
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 16;
    localparam int PTE_W    = 32;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 21;
    localparam int COUNT_W  = 10;
    localparam int CFG_W    = 9;

    typedef logic [WORD_W-1:0]   t_word_idx;
    typedef logic [MAP_BITS-1:0] t_map_word;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE_IDX = 2'd1,
        OP_FREE_PTE = 2'd2,
        OP_INIT     = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_NO_FREE     = 3'd1,
        STAT_RANGE       = 3'd2,
        STAT_PTE_INVALID = 3'd3,
        STAT_ALREADY     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_FREE,
        S_INIT
    } t_state;

    // One read and one write request to the map memory per cycle.
    typedef struct packed {
        logic      rd_en;
        t_word_idx rd_word;
        logic      wr_en;
        t_word_idx wr_word;
        t_map_word wr_data;
    } t_map_req;

endpackage

// ----- design/pfba_map_mem.sv -----
module pfba_map_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfba_pkg::t_map_req  i_req,
    output pfba_pkg::t_map_word o_rd_data
);

    pfba_pkg::t_map_word r_mem [pfba_pkg::MAP_WORDS];
    logic [pfba_pkg::MAP_WORDS-1:0] r_valid;
    pfba_pkg::t_map_word r_rd_data;
    logic r_rd_valid;

    // Map storage: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_word] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_word];
        end
    end

    // A word never written since reset reads as all pages free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_word] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_word];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ----- design/pfba_ctrl.sv -----
module pfba_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pfba_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic [pfba_pkg::INDEX_W-1:0]        i_page_index,
    input  logic [pfba_pkg::PTE_W-1:0]          i_pte_word,
    input  logic                                i_cfg_valid,
    input  logic [pfba_pkg::CFG_W-1:0]          i_cfg_data,
    output pfba_pkg::t_map_req                  o_req,
    input  pfba_pkg::t_map_word                 i_rd_data,
    output logic                                o_strobe,
    output logic [pfba_pkg::STATUS_W-1:0]       o_status,
    output logic [pfba_pkg::ADDR_W-1:0]         o_page_address,
    output logic [pfba_pkg::COUNT_W-1:0]        o_free_count
);

    pfba_pkg::t_state  r_state, n_state;
    pfba_pkg::t_opcode r_op, n_op;
    logic [pfba_pkg::PAGE_W-1:0] r_page, n_page;
    pfba_pkg::t_word_idx r_word, n_word;
    logic [pfba_pkg::PAGE_W-1:0] r_last, n_last;
    logic [pfba_pkg::CFG_W-1:0] r_cfg;
    logic [pfba_pkg::COUNT_W-1:0] r_free, n_free;
    logic r_strobe, n_strobe;
    pfba_pkg::t_status r_status, n_status;
    logic [pfba_pkg::ADDR_W-1:0] r_addr, n_addr;

    pfba_pkg::t_map_word scan_word;
    logic [pfba_pkg::BIT_W-1:0] free_bit;
    logic [pfba_pkg::PAGE_W-1:0] pte_page;
    logic [pfba_pkg::PAGE_W-1:0] cfg_last;
    pfba_pkg::t_map_word init_word;
    pfba_pkg::t_map_word page_bit;

    // Position of the lowest clear bit of a map word.
    function automatic logic [pfba_pkg::BIT_W-1:0] lowest_zero(input pfba_pkg::t_map_word w);
        logic [pfba_pkg::BIT_W-1:0] idx;
        idx = '0;
        for (int i = pfba_pkg::MAP_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = pfba_pkg::BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // Configuration register holding the last page kept for the system.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // State, count and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pfba_pkg::S_IDLE;
            r_free   <= pfba_pkg::COUNT_W'(pfba_pkg::NUM_PAGES);
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_page   <= n_page;
        r_word   <= n_word;
        r_last   <= n_last;
        r_status <= n_status;
        r_addr   <= n_addr;
    end

    // Pages past the end of the memory in the last word count as taken.
    always_comb begin
        scan_word = i_rd_data;
        if (pfba_pkg::TAIL_PAGES != 0
                && r_word == pfba_pkg::WORD_W'(pfba_pkg::MAP_WORDS - 1)) begin
            scan_word = i_rd_data
                | ~((pfba_pkg::t_map_word'(1) << pfba_pkg::TAIL_PAGES) - 1'b1);
        end
    end

    assign free_bit = lowest_zero(scan_word);
    assign pte_page = i_pte_word[pfba_pkg::PAGE_SIZE_LOG2 +: pfba_pkg::PAGE_W];
    assign page_bit = pfba_pkg::t_map_word'(1) << r_page[pfba_pkg::BIT_W-1:0];

    // The reservation is clamped to the last page of the memory.
    assign cfg_last = (32'(r_cfg) >= pfba_pkg::NUM_PAGES)
        ? pfba_pkg::PAGE_W'(pfba_pkg::NUM_PAGES - 1)
        : pfba_pkg::PAGE_W'(r_cfg);

    // Init pattern of the current word: full below the last reserved word,
    // a low run of ones in it, and clear above it.
    always_comb begin
        if (r_word < r_last[pfba_pkg::PAGE_W-1:pfba_pkg::BIT_W]) begin
            init_word = '1;
        end else if (r_word == r_last[pfba_pkg::PAGE_W-1:pfba_pkg::BIT_W]) begin
            init_word = pfba_pkg::t_map_word'('1)
                >> (pfba_pkg::BIT_W'(pfba_pkg::MAP_BITS - 1) - r_last[pfba_pkg::BIT_W-1:0]);
        end else begin
            init_word = '0;
        end
    end

    // Sequencer: next state, memory requests and results.
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_page   = r_page;
        n_word   = r_word;
        n_last   = r_last;
        n_free   = r_free;
        n_strobe = 1'b0;
        n_status = r_status;
        n_addr   = r_addr;
        o_req    = '0;

        case (r_state)
            pfba_pkg::S_IDLE: begin
                if (start) begin
                    n_op     = pfba_pkg::t_opcode'(i_opcode);
                    n_addr   = '0;
                    n_status = pfba_pkg::STAT_OK;
                    case (pfba_pkg::t_opcode'(i_opcode))
                        pfba_pkg::OP_ALLOC: begin
                            n_word = '0;
                            if (r_free == '0) begin
                                n_status = pfba_pkg::STAT_NO_FREE;
                                n_strobe = 1'b1;
                            end else begin
                                n_state = pfba_pkg::S_READ;
                            end
                        end
                        pfba_pkg::OP_FREE_IDX: begin
                            n_page = i_page_index[pfba_pkg::PAGE_W-1:0];
                            n_word = i_page_index[pfba_pkg::PAGE_W-1:pfba_pkg::BIT_W];
                            if (32'(i_page_index) >= pfba_pkg::NUM_PAGES) begin
                                n_status = pfba_pkg::STAT_RANGE;
                                n_strobe = 1'b1;
                            end else begin
                                n_state = pfba_pkg::S_READ;
                            end
                        end
                        pfba_pkg::OP_FREE_PTE: begin
                            n_page = pte_page;
                            n_word = pte_page[pfba_pkg::PAGE_W-1:pfba_pkg::BIT_W];
                            if (!i_pte_word[0]) begin
                                n_status = pfba_pkg::STAT_PTE_INVALID;
                                n_strobe = 1'b1;
                            end else if ((i_pte_word >> pfba_pkg::PAGE_SIZE_LOG2)
                                    >= pfba_pkg::PTE_W'(pfba_pkg::NUM_PAGES)) begin
                                n_status = pfba_pkg::STAT_RANGE;
                                n_strobe = 1'b1;
                            end else begin
                                n_state = pfba_pkg::S_READ;
                            end
                        end
                        pfba_pkg::OP_INIT: begin
                            n_word  = '0;
                            n_last  = cfg_last;
                            n_state = pfba_pkg::S_INIT;
                        end
                        default: begin
                            n_state = pfba_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // Fetch the first word of a scan or the word of the page to free.
            pfba_pkg::S_READ: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_word = r_word;
                n_state = (r_op == pfba_pkg::OP_ALLOC) ? pfba_pkg::S_SCAN : pfba_pkg::S_FREE;
            end

            // One word a cycle; the next read is issued while this one is checked.
            pfba_pkg::S_SCAN: begin
                if (scan_word != '1) begin
                    o_req.wr_en   = 1'b1;
                    o_req.wr_word = r_word;
                    o_req.wr_data = i_rd_data | (pfba_pkg::t_map_word'(1) << free_bit);
                    n_free   = r_free - 1'b1;
                    n_addr   = pfba_pkg::ADDR_W'({r_word, free_bit}) << pfba_pkg::PAGE_SIZE_LOG2;
                    n_status = pfba_pkg::STAT_OK;
                    n_strobe = 1'b1;
                    n_state  = pfba_pkg::S_IDLE;
                end else if (r_word == pfba_pkg::WORD_W'(pfba_pkg::MAP_WORDS - 1)) begin
                    n_status = pfba_pkg::STAT_NO_FREE;
                    n_strobe = 1'b1;
                    n_state  = pfba_pkg::S_IDLE;
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_word = r_word + 1'b1;
                    n_word = r_word + 1'b1;
                end
            end

            // Clear the page's bit unless it is already clear.
            pfba_pkg::S_FREE: begin
                if ((i_rd_data & page_bit) == '0) begin
                    n_status = pfba_pkg::STAT_ALREADY;
                end else begin
                    o_req.wr_en   = 1'b1;
                    o_req.wr_word = r_word;
                    o_req.wr_data = i_rd_data & ~page_bit;
                    n_free   = r_free + 1'b1;
                    n_status = pfba_pkg::STAT_OK;
                end
                n_strobe = 1'b1;
                n_state  = pfba_pkg::S_IDLE;
            end

            // Write every word of the map in turn.
            pfba_pkg::S_INIT: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_word = r_word;
                o_req.wr_data = init_word;
                n_word = r_word + 1'b1;
                if (r_word == pfba_pkg::WORD_W'(pfba_pkg::MAP_WORDS - 1)) begin
                    n_free = pfba_pkg::COUNT_W'(pfba_pkg::NUM_PAGES - 1)
                        - pfba_pkg::COUNT_W'(r_last);
                    n_status = pfba_pkg::STAT_OK;
                    n_strobe = 1'b1;
                    n_state  = pfba_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = pfba_pkg::S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != pfba_pkg::S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_page_address = r_addr;
    assign o_free_count   = r_free;

endmodule

// ----- design/page_frame_bitmap_allocator.sv -----
// First-fit page frame allocator over a one-bit-per-page in-use map held in a
// small synchronous memory of 32-bit words, with a running free-page count.
// A command word is taken when start is high and busy is low; its result word
// appears on the result ports for exactly one cycle with o_strobe high, and the
// receiver must take it then, as there is no way to hold it off. Errors found
// from the command alone (no free page by count, index or PTE page out of
// range, invalid PTE) give the result in the cycle after acceptance. A free is
// busy for a memory read, then a check and write back. An allocation is busy
// for a read of the first map word, then a scan that reads one word per cycle
// through the single read port up to the first word with a clear bit or the
// last word. Init writes every map word, one per cycle. The configuration word
// is always taken and should be written only while the block is idle.
module page_frame_bitmap_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pfba_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [pfba_pkg::INDEX_W-1:0]      i_page_index,
    input  logic [pfba_pkg::PTE_W-1:0]        i_pte_word,
    output logic                              o_strobe,
    output logic [pfba_pkg::STATUS_W-1:0]     o_status,
    output logic [pfba_pkg::ADDR_W-1:0]       o_page_address,
    output logic [pfba_pkg::COUNT_W-1:0]      o_free_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pfba_pkg::CFG_W-1:0]        i_cfg_data
);

    pfba_pkg::t_map_req  map_req;
    pfba_pkg::t_map_word map_rd_data;

    // The configuration register can be written in any cycle.
    assign o_cfg_ready = 1'b1;

    pfba_map_mem u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_data (map_rd_data)
    );

    pfba_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_page_index   (i_page_index),
        .i_pte_word     (i_pte_word),
        .i_cfg_valid    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_req          (map_req),
        .i_rd_data      (map_rd_data),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_page_address (o_page_address),
        .o_free_count   (o_free_count)
    );

    // A result only follows an accepted command or a busy cycle.
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(start) || $past(busy)))
        else $error("result word without a command in progress");

    // Finishing a busy command always yields its result word.
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("command finished without a result word");

    // Failed commands report no page address.
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != pfba_pkg::STAT_OK) |-> (o_page_address == '0))
        else $error("page address given with a failure status");

    // The free count never exceeds the number of pages.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(o_free_count) <= pfba_pkg::NUM_PAGES)
        else $error("free count beyond page count");

    // A successful allocation of any page but page 0 takes exactly one page from the count.
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == pfba_pkg::STAT_OK && o_page_address != '0)
        |-> (o_free_count == $past(o_free_count) - 1'b1))
        else $error("allocation did not take one page from the count");

endmodule

// ----- sim/page_frame_bitmap_allocator_tb.sv -----
module page_frame_bitmap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 4;
    localparam int STALL_LIMIT     = 2000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int SETTLE_CYCLES   = 20;

    // Expected result word for one command.
    typedef struct {
        pfba_pkg::t_status                 status;
        logic [pfba_pkg::ADDR_W-1:0]       addr;
        logic [pfba_pkg::COUNT_W-1:0]      count;
    } t_outcome;

    // Shadow copy of the page map, plus the queue of result words still to come.
    class page_ledger;
        logic [pfba_pkg::NUM_PAGES-1:0] in_use;
        int unsigned                    free_pages;
        logic [pfba_pkg::CFG_W-1:0]     reserved_last;
        t_outcome                       outcome_q[$];
        int                             errors;

        function new();
            in_use        = '0;
            free_pages    = pfba_pkg::NUM_PAGES;
            reserved_last = '0;
            errors        = 0;
        endfunction

        function void set_reserved(logic [pfba_pkg::CFG_W-1:0] value);
            reserved_last = value;
        endfunction

        // A page that is currently in use, searching from a random point, or that point if none is.
        function int unsigned pick_used();
            int unsigned origin;
            origin = $urandom_range(0, pfba_pkg::NUM_PAGES - 1);
            for (int k = 0; k < pfba_pkg::NUM_PAGES; k++) begin
                if (in_use[(origin + k) % pfba_pkg::NUM_PAGES]) begin
                    return (origin + k) % pfba_pkg::NUM_PAGES;
                end
            end
            return origin;
        endfunction

        function pfba_pkg::t_status release_page(int unsigned page);
            if (page >= pfba_pkg::NUM_PAGES) begin
                return pfba_pkg::STAT_RANGE;
            end
            if (!in_use[page]) begin
                return pfba_pkg::STAT_ALREADY;
            end
            in_use[page] = 1'b0;
            free_pages++;
            return pfba_pkg::STAT_OK;
        endfunction

        // Work out the result of an accepted command and queue it.
        function void note_command(pfba_pkg::t_opcode op,
                                   logic [pfba_pkg::INDEX_W-1:0] idx,
                                   logic [pfba_pkg::PTE_W-1:0] pte);
            t_outcome    o;
            int unsigned last;
            bit          found;
            o.status = pfba_pkg::STAT_OK;
            o.addr   = '0;
            found    = 1'b0;
            case (op)
                pfba_pkg::OP_ALLOC: begin
                    if (free_pages != 0) begin
                        for (int p = 0; p < pfba_pkg::NUM_PAGES && !found; p++) begin
                            if (!in_use[p]) begin
                                in_use[p] = 1'b1;
                                free_pages--;
                                o.addr = pfba_pkg::ADDR_W'(p << pfba_pkg::PAGE_SIZE_LOG2);
                                found  = 1'b1;
                            end
                        end
                    end
                    if (!found) begin
                        o.status = pfba_pkg::STAT_NO_FREE;
                    end
                end
                pfba_pkg::OP_FREE_IDX: begin
                    o.status = release_page(idx);
                end
                pfba_pkg::OP_FREE_PTE: begin
                    if (!pte[0]) begin
                        o.status = pfba_pkg::STAT_PTE_INVALID;
                    end else begin
                        o.status = release_page(pte >> pfba_pkg::PAGE_SIZE_LOG2);
                    end
                end
                default: begin
                    // Init reserves the low pages, clamped to the end of memory.
                    last = reserved_last;
                    if (last >= pfba_pkg::NUM_PAGES) begin
                        last = pfba_pkg::NUM_PAGES - 1;
                    end
                    in_use = '0;
                    for (int p = 0; p <= last; p++) begin
                        in_use[p] = 1'b1;
                    end
                    free_pages = pfba_pkg::NUM_PAGES - (last + 1);
                end
            endcase
            o.count = pfba_pkg::COUNT_W'(free_pages);
            outcome_q.push_back(o);
        endfunction

        task report(string what, int unsigned expected_val, int unsigned got_val);
            $display("%0t ns: mismatch in %s, expected %0h, got %0h",
                     $time, what, expected_val, got_val);
            errors++;
        endtask

        // Compare one result word with the oldest expectation.
        task check_result(logic [pfba_pkg::STATUS_W-1:0] status,
                          logic [pfba_pkg::ADDR_W-1:0] addr,
                          logic [pfba_pkg::COUNT_W-1:0] count);
            t_outcome o;
            if (outcome_q.size() == 0) begin
                report("unexpected result word status", 0, status);
                return;
            end
            o = outcome_q.pop_front();
            if (status !== o.status) begin
                report("status", o.status, status);
            end
            if (addr !== o.addr) begin
                report("page_address", o.addr, addr);
            end
            if (count !== o.count) begin
                report("free_count", o.count, count);
            end
        endtask
    endclass

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          start        = 1'b0;
    logic                          busy;
    logic [pfba_pkg::OPCODE_W-1:0] i_opcode     = '0;
    logic [pfba_pkg::INDEX_W-1:0]  i_page_index = '0;
    logic [pfba_pkg::PTE_W-1:0]    i_pte_word   = '0;
    logic                          o_strobe;
    logic [pfba_pkg::STATUS_W-1:0] o_status;
    logic [pfba_pkg::ADDR_W-1:0]   o_page_address;
    logic [pfba_pkg::COUNT_W-1:0]  o_free_count;
    logic                          i_cfg_valid  = 1'b0;
    logic                          o_cfg_ready;
    logic [pfba_pkg::CFG_W-1:0]    i_cfg_data   = '0;

    page_ledger                    ledger;
    int                            stall_cycles = 0;
    logic [pfba_pkg::CFG_W-1:0]    phase_reserved [PHASES];

    page_frame_bitmap_allocator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_page_index   (i_page_index),
        .i_pte_word     (i_pte_word),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_page_address (o_page_address),
        .o_free_count   (o_free_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // Free-running clock.
    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Every result word is checked in the cycle it is offered.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            ledger.check_result(o_status, o_page_address, o_free_count);
        end
    end

    // Give up once nothing has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one command word after a gap and wait until it is taken.
    task automatic send_command(pfba_pkg::t_opcode op, logic [pfba_pkg::INDEX_W-1:0] idx,
                                logic [pfba_pkg::PTE_W-1:0] pte, int unsigned gap);
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_page_index <= idx;
        i_pte_word   <= pte;
        do @(posedge i_clk); while (busy);
        ledger.note_command(op, idx, pte);
    endtask

    // Stop offering commands and wait until every result word has come back.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (ledger.outcome_q.size() != 0 || busy) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // The reserved-page register is only written while the block is idle.
    task automatic write_reserved(logic [pfba_pkg::CFG_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.set_reserved(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly frees of pages in use and allocations, with some noise.
    task automatic random_command(bit with_gaps);
        int unsigned                  pick;
        int unsigned                  choice;
        int unsigned                  gap;
        pfba_pkg::t_opcode            op;
        logic [pfba_pkg::INDEX_W-1:0] idx;
        logic [pfba_pkg::PTE_W-1:0]   pte;
        pick   = $urandom_range(0, 99);
        choice = $urandom_range(0, 9);
        idx    = $urandom;
        pte    = $urandom;
        gap    = with_gaps ? $urandom_range(0, 8) : 0;
        if (pick < 45) begin
            op = pfba_pkg::OP_ALLOC;
        end else if (pick < 70) begin
            op = pfba_pkg::OP_FREE_IDX;
            if (choice < 5) begin
                idx = ledger.pick_used();
            end else if (choice < 8) begin
                idx = $urandom_range(0, pfba_pkg::NUM_PAGES - 1);
            end
        end else if (pick < 96) begin
            op = pfba_pkg::OP_FREE_PTE;
            if (choice < 5) begin
                pte = (pfba_pkg::PTE_W'(ledger.pick_used()) << pfba_pkg::PAGE_SIZE_LOG2)
                      | (pte & 32'hFFF);
            end else if (choice < 8) begin
                pte = (pfba_pkg::PTE_W'($urandom_range(0, pfba_pkg::NUM_PAGES - 1))
                       << pfba_pkg::PAGE_SIZE_LOG2) | (pte & 32'hFFF);
            end
            if (choice < 8) begin
                pte[0] = ($urandom_range(0, 99) < 85);
            end
        end else begin
            op = pfba_pkg::OP_INIT;
        end
        send_command(op, idx, pte, gap);
        if ($urandom_range(0, 49) == 0) begin
            drain();
        end
    endtask

    initial begin
        ledger = new();
        phase_reserved[0] = 9'd511;
        phase_reserved[1] = 9'd0;
        phase_reserved[2] = 9'($urandom_range(0, pfba_pkg::NUM_PAGES - 1));
        phase_reserved[3] = 9'd500;
        phase_reserved[4] = 9'($urandom_range(0, pfba_pkg::NUM_PAGES - 1));
        phase_reserved[5] = 9'd255;
        phase_reserved[6] = 9'($urandom_range(400, pfba_pkg::NUM_PAGES - 1));
        phase_reserved[7] = 9'd480;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every error but no free page on a fresh map, frees by both routes.
        send_command(pfba_pkg::OP_ALLOC, 16'd0, 32'd0, 0);
        send_command(pfba_pkg::OP_FREE_IDX, 16'd0, 32'd0, 2);
        send_command(pfba_pkg::OP_FREE_IDX, 16'd0, 32'd0, 0);
        send_command(pfba_pkg::OP_FREE_IDX, 16'd512, 32'd0, 0);
        send_command(pfba_pkg::OP_FREE_IDX, 16'hFFFF, 32'd0, 5);
        send_command(pfba_pkg::OP_FREE_PTE, 16'd0, 32'hFFFF_FFFE, 0);
        send_command(pfba_pkg::OP_FREE_PTE, 16'd0, 32'hFFFF_FFFF, 0);
        send_command(pfba_pkg::OP_ALLOC, 16'd0, 32'd0, 1);
        send_command(pfba_pkg::OP_FREE_PTE, 16'd0, 32'h0000_0FFF, 0);
        send_command(pfba_pkg::OP_FREE_PTE, 16'd0, 32'h001F_F001, 0);
        send_command(pfba_pkg::OP_INIT, 16'd0, 32'd0, 0);

        // Directed: reserving every page leaves nothing to allocate.
        write_reserved(9'd511);
        send_command(pfba_pkg::OP_INIT, 16'd0, 32'd0, 0);
        send_command(pfba_pkg::OP_ALLOC, 16'd0, 32'd0, 0);
        send_command(pfba_pkg::OP_FREE_IDX, 16'd511, 32'd0, 0);
        send_command(pfba_pkg::OP_ALLOC, 16'd0, 32'd0, 3);
        send_command(pfba_pkg::OP_ALLOC, 16'd0, 32'd0, 0);
        send_command(pfba_pkg::OP_FREE_PTE, 16'd0, 32'h0000_5001, 0);
        send_command(pfba_pkg::OP_ALLOC, 16'd0, 32'd0, 8);

        // Random phases, each under its own reservation, half without gaps.
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reserved(phase_reserved[ph]);
            send_command(pfba_pkg::OP_INIT, 16'd0, 32'd0, 0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                random_command(ph % 2 == 0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.outcome_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
